// ----- hdl/rau_pkg.sv -----
// ----------------------------------------------------------------------------
// rau_pkg
// shared types and constants of the rational arithmetic unit
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int DEF_WORD_BITS = 32;
    localparam int FIELD_BITS    = 32;
    localparam int EXP_BITS      = 6;
    localparam int CMD_BITS      = 3;

    localparam logic [CMD_BITS-1:0] CMD_ADD = 3'd0;
    localparam logic [CMD_BITS-1:0] CMD_SUB = 3'd1;
    localparam logic [CMD_BITS-1:0] CMD_MUL = 3'd2;
    localparam logic [CMD_BITS-1:0] CMD_DIV = 3'd3;
    localparam logic [CMD_BITS-1:0] CMD_ABS = 3'd4;
    localparam logic [CMD_BITS-1:0] CMD_POW = 3'd5;

    // one queued transaction, at the full field width
    typedef struct packed {
        logic [CMD_BITS-1:0]   cmd;
        logic [FIELD_BITS-1:0] an;
        logic [FIELD_BITS-1:0] ad;
        logic [FIELD_BITS-1:0] bn;
        logic [FIELD_BITS-1:0] bd;
        logic [EXP_BITS-1:0]   expo;
    } rau_cmd_t;

endpackage

// ----- hdl/rau_front.sv -----
// ----------------------------------------------------------------------------
// rau_front
// command intake and two-entry queue toward the execution engine
// ----------------------------------------------------------------------------
module rau_front
    import rau_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  rau_cmd_t push_data,
    output logic     full,
    input  logic     pop,
    output logic     not_empty,
    output rau_cmd_t head
);

    rau_cmd_t   mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign head      = mem_reg[rp_reg];

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push && !full)
            mem_reg[wp_reg] <= push_data;
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push && !full)
                wp_reg <= ~wp_reg;
            if (pop && not_empty)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, (push && !full)} - {1'b0, (pop && not_empty)};
        end
    end

endmodule

// ----- hdl/rau_back.sv -----
// ----------------------------------------------------------------------------
// rau_back
// sequencer: products, powers, gcd by repeated remainder, reduction
// ----------------------------------------------------------------------------
module rau_back
    import rau_pkg::*;
#(
    parameter int WORD_BITS = DEF_WORD_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  avail,
    input  rau_cmd_t              cmd_in,
    output logic                  take,
    output logic                  done,
    output logic [FIELD_BITS-1:0] res_n,
    output logic [FIELD_BITS-1:0] res_d,
    output logic                  res_ovf
);

    localparam int W  = WORD_BITS;
    localparam int CW = $clog2(W + 1);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_P1    = 11'b00000000010,
        S_P2    = 11'b00000000100,
        S_P3    = 11'b00000001000,
        S_P4    = 11'b00000010000,
        S_SUM   = 11'b00000100000,
        S_POW   = 11'b00001000000,
        S_CHK   = 11'b00010000000,
        S_GCD   = 11'b00100000000,
        S_DIVN  = 11'b01000000000,
        S_DIVD  = 11'b10000000000
    } st_t;

    st_t st_reg, st_next;

    logic signed [W-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic [CMD_BITS-1:0] cmd_reg;
    logic signed [W-1:0] p1_reg, p2_reg, n_reg, d_reg;
    logic                ovf_reg;
    logic [5:0]          k_reg;
    logic                eneg_reg;
    // shared multiplier operands
    logic signed [W-1:0] ma, mb;
    logic signed [2*W-1:0] prod;
    logic                  pov;
    // divider state: dividend/remainder and divisor
    logic [W-1:0]  dq_reg, dr_reg, dv_reg;
    logic [CW-1:0] bit_reg;
    logic          dvbusy_reg;
    logic [W-1:0]  gx_reg, gy_reg;
    logic          dneg_reg, nneg_reg;
    logic          out_v_reg;
    logic signed [W-1:0] rn_reg, rd_reg;

    always_comb
    begin
        ma = p1_reg;
        mb = p2_reg;
        prod = ma * mb;
        pov  = (prod != {{W{prod[W-1]}}, prod[W-1:0]});
    end

    function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
        mag = v[W-1] ? -v : v;
    endfunction

    // restoring divide step: remainder shifted and compared
    logic [W:0]   rem_sh;
    logic [W:0]   rem_sub;
    always_comb
    begin
        rem_sh  = {dr_reg, dq_reg[W-1]};
        rem_sub = rem_sh - {1'b0, dv_reg};
    end

    assign take    = (st_reg == S_IDLE) && avail;
    assign done    = out_v_reg;
    assign res_n   = FIELD_BITS'(rn_reg);
    assign res_d   = FIELD_BITS'(rd_reg);
    assign res_ovf = ovf_reg;

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            S_IDLE: if (avail) st_next = S_P1;
            default: st_next = st_reg;
        endcase
    end

    logic signed [W-1:0] nn;
    logic signed [W:0]   sx;
    always_comb
    begin
        sx = (cmd_reg == CMD_ADD) ? ({p1_reg[W-1], p1_reg} + {p2_reg[W-1], p2_reg})
                                  : ({p1_reg[W-1], p1_reg} - {p2_reg[W-1], p2_reg});
        nn = sx[W-1:0];
    end

    // main sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= S_IDLE;
            out_v_reg  <= 1'b0;
            dvbusy_reg <= 1'b0;
        end
        else
        begin
            out_v_reg <= 1'b0;
            case (st_reg)
                S_IDLE:
                begin
                    if (st_next == S_P1)
                    begin
                        cmd_reg  <= cmd_in.cmd;
                        an_reg   <= W'(cmd_in.an);
                        ad_reg   <= W'(cmd_in.ad);
                        bn_reg   <= W'(cmd_in.bn);
                        bd_reg   <= W'(cmd_in.bd);
                        ovf_reg  <= 1'b0;
                        eneg_reg <= cmd_in.expo[EXP_BITS-1];
                        k_reg    <= cmd_in.expo[EXP_BITS-1] ? 6'(-cmd_in.expo)
                                                            : cmd_in.expo;
                        st_reg   <= S_P1;
                        // first multiplier operands
                        p1_reg   <= W'(cmd_in.an);
                        p2_reg   <= (cmd_in.cmd == CMD_MUL) ? W'(cmd_in.bn) : W'(cmd_in.bd);
                    end
                end
                S_P1:
                begin
                    case (cmd_reg)
                        CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV:
                        begin
                            n_reg   <= prod[W-1:0];
                            ovf_reg <= ovf_reg | pov;
                            p1_reg  <= ad_reg;
                            p2_reg  <= (cmd_reg == CMD_DIV) ? bn_reg : bd_reg;
                            st_reg  <= S_P2;
                        end
                        CMD_ABS:
                        begin
                            n_reg   <= an_reg[W-1] ? -an_reg : an_reg;
                            d_reg   <= ad_reg[W-1] ? -ad_reg : ad_reg;
                            ovf_reg <= (an_reg == {1'b1, {(W-1){1'b0}}})
                                     | (ad_reg == {1'b1, {(W-1){1'b0}}});
                            st_reg  <= S_CHK;
                        end
                        CMD_POW:
                        begin
                            // bases held in bn/bd, swapped for a negative exponent
                            bn_reg <= eneg_reg ? ad_reg : an_reg;
                            bd_reg <= eneg_reg ? an_reg : ad_reg;
                            n_reg  <= W'(1);
                            d_reg  <= W'(1);
                            st_reg <= S_POW;
                        end
                        default:
                        begin
                            n_reg  <= '0;
                            d_reg  <= W'(1);
                            st_reg <= S_CHK;
                        end
                    endcase
                end
                S_P2:
                begin
                    d_reg   <= prod[W-1:0];
                    ovf_reg <= ovf_reg | pov;
                    if (cmd_reg == CMD_ADD || cmd_reg == CMD_SUB)
                    begin
                        p1_reg <= bn_reg;
                        p2_reg <= ad_reg;
                        st_reg <= S_P3;
                    end
                    else
                        st_reg <= S_CHK;
                end
                S_P3:
                begin
                    p1_reg  <= n_reg;
                    p2_reg  <= prod[W-1:0];
                    ovf_reg <= ovf_reg | pov;
                    st_reg  <= S_SUM;
                end
                S_SUM:
                begin
                    n_reg   <= nn;
                    ovf_reg <= ovf_reg | (sx[W] != sx[W-1]);
                    st_reg  <= S_CHK;
                end
                S_POW:
                begin
                    // alternate: multiply numerator, then denominator
                    if (k_reg == 6'd0)
                        st_reg <= S_CHK;
                    else
                    begin
                        st_reg <= S_P4;
                        p1_reg <= n_reg;
                        p2_reg <= bn_reg;
                    end
                end
                S_P4:
                begin
                    if (!dvbusy_reg)
                    begin
                        n_reg      <= prod[W-1:0];
                        ovf_reg    <= ovf_reg | pov;
                        p1_reg     <= d_reg;
                        p2_reg     <= bd_reg;
                        dvbusy_reg <= 1'b1;
                    end
                    else
                    begin
                        d_reg      <= prod[W-1:0];
                        ovf_reg    <= ovf_reg | pov;
                        dvbusy_reg <= 1'b0;
                        k_reg      <= k_reg - 6'd1;
                        st_reg     <= S_POW;
                    end
                end
                S_CHK:
                begin
                    if (n_reg == '0)
                    begin
                        rn_reg <= '0; rd_reg <= W'(1);
                        out_v_reg <= 1'b1; st_reg <= S_IDLE;
                    end
                    else if (d_reg == '0)
                    begin
                        rn_reg <= n_reg; rd_reg <= d_reg;
                        out_v_reg <= 1'b1; st_reg <= S_IDLE;
                    end
                    else
                    begin
                        gx_reg <= mag(n_reg);
                        gy_reg <= mag(d_reg);
                        st_reg <= S_GCD;
                        dvbusy_reg <= 1'b0;
                    end
                end
                S_GCD:
                begin
                    // euclid: each remainder by a W-step restoring divider
                    if (!dvbusy_reg)
                    begin
                        if (gy_reg == '0)
                        begin
                            nneg_reg   <= n_reg[W-1];
                            dq_reg     <= mag(n_reg);
                            dr_reg     <= '0;
                            dv_reg     <= gx_reg;
                            bit_reg    <= CW'(W);
                            dvbusy_reg <= 1'b1;
                            st_reg     <= S_DIVN;
                        end
                        else
                        begin
                            dq_reg     <= gx_reg;
                            dr_reg     <= '0;
                            dv_reg     <= gy_reg;
                            bit_reg    <= CW'(W);
                            dvbusy_reg <= 1'b1;
                        end
                    end
                    else if (bit_reg != '0)
                    begin
                        dq_reg  <= {dq_reg[W-2:0], ~rem_sub[W]};
                        dr_reg  <= rem_sub[W] ? rem_sh[W-1:0] : rem_sub[W-1:0];
                        bit_reg <= bit_reg - CW'(1);
                    end
                    else
                    begin
                        gx_reg     <= gy_reg;
                        gy_reg     <= dr_reg;
                        dvbusy_reg <= 1'b0;
                    end
                end
                S_DIVN:
                begin
                    if (bit_reg != '0)
                    begin
                        dq_reg  <= {dq_reg[W-2:0], ~rem_sub[W]};
                        dr_reg  <= rem_sub[W] ? rem_sh[W-1:0] : rem_sub[W-1:0];
                        bit_reg <= bit_reg - CW'(1);
                    end
                    else
                    begin
                        n_reg    <= nneg_reg ? -dq_reg : dq_reg;
                        dneg_reg <= d_reg[W-1];
                        dq_reg   <= mag(d_reg);
                        dr_reg   <= '0;
                        bit_reg  <= CW'(W);
                        st_reg   <= S_DIVD;
                    end
                end
                S_DIVD:
                begin
                    if (bit_reg != '0)
                    begin
                        dq_reg  <= {dq_reg[W-2:0], ~rem_sub[W]};
                        dr_reg  <= rem_sub[W] ? rem_sh[W-1:0] : rem_sub[W-1:0];
                        bit_reg <= bit_reg - CW'(1);
                    end
                    else
                    begin
                        // quotient q; signed d = dneg ? -q : q; fix sign
                        dvbusy_reg <= 1'b0;
                        out_v_reg  <= 1'b1;
                        st_reg     <= S_IDLE;
                        if (dneg_reg && dq_reg != {1'b1, {(W-1){1'b0}}})
                        begin
                            rn_reg  <= -n_reg;
                            rd_reg  <= dq_reg;
                            ovf_reg <= ovf_reg | (n_reg == {1'b1, {(W-1){1'b0}}});
                        end
                        else if (dneg_reg)
                        begin
                            rn_reg  <= -n_reg;
                            rd_reg  <= dq_reg;
                            ovf_reg <= 1'b1;
                        end
                        else
                        begin
                            rn_reg <= n_reg;
                            rd_reg <= dq_reg;
                        end
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- hdl/rational_arithmetic_unit.sv -----
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// exact fraction add, subtract, multiply, divide, absolute value and power
// ----------------------------------------------------------------------------
// usage:
//   a transaction is taken at a clock edge with start high and busy low.
//   the command and operands enter a two-entry queue; busy is high while it
//   is full. the engine pulls one transaction at a time and presents
//   result_numerator, result_denominator and overflow for one cycle with
//   done high. the receiver cannot stall; one result per transaction.
// sequencing (the engine works one transaction at a time):
//   raw pair: absolute directly, multiply and divide by two products, add
//   and subtract by three products and a sum, power by a numerator and a
//   denominator product per exponent step. a zero numerator or denominator
//   then finishes without reduction. otherwise euclid finds the gcd by
//   repeated remainder on the restoring divider, and the two final
//   divisions divide numerator and denominator by it; the divider loop
//   dominates the run time.
// reset:
//   rst_n clears the queue and the engine; no transaction is pending after.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit
    import rau_pkg::*;
#(
    parameter int WORD_BITS = DEF_WORD_BITS
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [CMD_BITS-1:0]          command,
    input  logic signed [FIELD_BITS-1:0] a_numerator,
    input  logic signed [FIELD_BITS-1:0] a_denominator,
    input  logic signed [FIELD_BITS-1:0] b_numerator,
    input  logic signed [FIELD_BITS-1:0] b_denominator,
    input  logic signed [EXP_BITS-1:0]   exponent,
    output logic                         done,
    output logic signed [FIELD_BITS-1:0] result_numerator,
    output logic signed [FIELD_BITS-1:0] result_denominator,
    output logic                         overflow
);

    rau_cmd_t in_cmd, head;
    logic     full, avail, take;
    logic [FIELD_BITS-1:0] rn, rd;

    assign in_cmd = '{cmd: command, an: a_numerator, ad: a_denominator,
                      bn: b_numerator, bd: b_denominator, expo: exponent};
    assign busy   = full;

    // command queue
    rau_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (start),
        .push_data (in_cmd),
        .full      (full),
        .pop       (take),
        .not_empty (avail),
        .head      (head)
    );

    // execution engine
    rau_back #(.WORD_BITS(WORD_BITS)) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .avail   (avail),
        .cmd_in  (head),
        .take    (take),
        .done    (done),
        .res_n   (rn),
        .res_d   (rd),
        .res_ovf (overflow)
    );

    // sign-extend from the word width
    assign result_numerator   = FIELD_BITS'(signed'(rn[WORD_BITS-1:0]));
    assign result_denominator = FIELD_BITS'(signed'(rd[WORD_BITS-1:0]));

    // no pull from an empty queue
    a_take: assert property (@(posedge clk) disable iff (!rst_n) take |-> avail)
        else $error("engine pulled from empty queue");
    // a finished result is not followed by another in the next cycle
    a_done: assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("back to back results");
    // a zero numerator always reports denominator one
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result_numerator == '0) |-> (result_denominator == 1))
        else $error("zero not normalized");

endmodule
